// ===== rtl/rfm_pkg.sv =====
// Shared types, constants and the segment decoder for the reciprocal
// frequency meter. No dependencies; every other file imports this package.
package rfm_pkg;

    // Width of the tick counter and of the period (17..48).
    localparam int PERIOD_WIDTH = 32;
    localparam int DIVIDEND_W   = 32;
    localparam int QUOT_W       = DIVIDEND_W;
    localparam int DIV_CNT_W    = $clog2(DIVIDEND_W);
    localparam int CENTI_W      = 14;
    localparam int BCD_DIGITS   = 4;
    localparam int BCD_W        = 4 * BCD_DIGITS;
    localparam int BCD_CNT_W    = $clog2(CENTI_W);
    localparam int PER_EXT_W    = (PERIOD_WIDTH > 32) ? PERIOD_WIDTH : 32;

    localparam logic [DIVIDEND_W-1:0] DIVIDEND_RESET = 32'd100000000;
    localparam logic [QUOT_W-1:0]     MAX_CENTIHZ    = 32'd9999;

    localparam logic [3:0] DIGIT_DASH = 4'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_BCD,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

    // Active-low segment drive: segments a..g on bits 0..6, dot on bit 7.
    function automatic logic [7:0] seg_drive(input logic [3:0] digit, input logic dot);
        logic [6:0] pat;
        begin
            case (digit)
                4'd0:    pat = 7'h3f;
                4'd1:    pat = 7'h06;
                4'd2:    pat = 7'h5b;
                4'd3:    pat = 7'h4f;
                4'd4:    pat = 7'h66;
                4'd5:    pat = 7'h6d;
                4'd6:    pat = 7'h7d;
                4'd7:    pat = 7'h07;
                4'd8:    pat = 7'h7f;
                4'd9:    pat = 7'h6f;
                default: pat = 7'h40;
            endcase
            return ~{dot, pat};
        end
    endfunction

endpackage

// ===== rtl/rfm_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frequency meter.
// Depends on rfm_pkg.
module rfm_div
    import rfm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [DIVIDEND_W-1:0]   dividend,
    input  logic [PERIOD_WIDTH-1:0] divisor,
    output unit_status_t            status,
    output logic [QUOT_W-1:0]       quotient
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [PERIOD_WIDTH-1:0] rem_reg, rem_next;
    logic [PERIOD_WIDTH-1:0] dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0]   dq_reg, dq_next;
    logic [PERIOD_WIDTH:0]   trial;
    logic [PERIOD_WIDTH:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, dq_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIVIDEND_W - 1);
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            // Subtract when the trial remainder covers the divisor.
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[PERIOD_WIDTH-1:0];
                dq_next  = {dq_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[PERIOD_WIDTH-1:0];
                dq_next  = {dq_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign status   = '{busy: busy_reg, done: done_reg};
    assign quotient = dq_reg;

endmodule

// ===== rtl/rfm_bcd.sv =====
// Shift-and-add-3 binary to BCD converter, one bit per cycle.
// Depends on rfm_pkg.
module rfm_bcd
    import rfm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [CENTI_W-1:0] value,
    output unit_status_t       status,
    output logic [BCD_W-1:0]   bcd
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [BCD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [CENTI_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     adj;

    always_comb
    begin
        // Add 3 to every digit of five or more before the shift.
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] inside {[4'd5:4'd15]})
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = BCD_CNT_W'(CENTI_W - 1);
            bcd_next  = '0;
            bin_next  = value;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[BCD_W-2:0], bin_reg[CENTI_W-1]};
            bin_next = {bin_reg[CENTI_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign status = '{busy: busy_reg, done: done_reg};
    assign bcd    = bcd_reg;

endmodule

// ===== rtl/reciprocal_frequency_meter_unit.sv =====
// Reciprocal frequency meter: tick counter, sequencer and output register.
// Depends on rfm_pkg, rfm_div and rfm_bcd.
// An edge-free tick leaves the sequencer idle and ready for the next tick; an
// edge tick holds off input while the 32-step divider runs and, for an
// in-range reading, the 14-step BCD converter, and until the output register
// is free to take the result. Reset (rst_n low, async) clears the counter,
// empties the output register and loads the dividend with 100000000.
module reciprocal_frequency_meter_unit
    import rfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [DIVIDEND_W-1:0] cfg_data,
    // tick channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  edge_req,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           period_ticks,
    output logic [CENTI_W-1:0]    centihertz,
    output logic                  in_range,
    output logic [7:0]            seg_tens,
    output logic [7:0]            seg_units,
    output logic [7:0]            seg_tenths,
    output logic [7:0]            seg_hundredths
);

    state_t                  state_reg, state_next;
    logic [DIVIDEND_W-1:0]   scale_reg;
    logic [PERIOD_WIDTH-1:0] count_reg, count_next;
    logic [PERIOD_WIDTH-1:0] period_reg, period_next;
    logic                    range_reg, range_next;
    logic                    in_xfer;
    logic [PERIOD_WIDTH-1:0] period_now;
    logic                    div_start;
    logic                    bcd_start;
    logic                    load;
    unit_status_t            div_status;
    unit_status_t            bcd_status;
    logic [QUOT_W-1:0]       quotient;
    logic [BCD_W-1:0]        bcd;
    logic [PER_EXT_W-1:0]    period_ext;

    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             period_out_reg;
    logic [CENTI_W-1:0]      centi_reg;
    logic                    range_out_reg;
    logic [7:0]              seg_tens_reg;
    logic [7:0]              seg_units_reg;
    logic [7:0]              seg_tenths_reg;
    logic [7:0]              seg_hund_reg;

    // The dividend is to be written only while idle; the user must keep to this, so accept every write.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= DIVIDEND_RESET;
        else if (cfg_valid && cfg_ready)
            scale_reg <= cfg_data;
    end

    // Ticks are taken only while the sequencer idles.
    assign in_ready = (state_reg == ST_IDLE);
    assign in_xfer  = in_valid && in_ready;

    // Period of this edge: count+1, held at full scale once saturated.
    assign period_now = (&count_reg) ? count_reg : count_reg + 1'b1;

    rfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (scale_reg),
        .divisor  (period_now),
        .status   (div_status),
        .quotient (quotient)
    );

    rfm_bcd u_bcd (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (bcd_start),
        .value  (quotient[CENTI_W-1:0]),
        .status (bcd_status),
        .bcd    (bcd)
    );

    // Sequencer: count ticks, run the divider, then (for an in-range reading) the
    // BCD converter, then wait for a free output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        period_next    = period_reg;
        range_next     = range_reg;
        div_start      = 1'b0;
        bcd_start      = 1'b0;
        load           = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (edge_req)
                    begin
                        period_next = period_now;
                        count_next  = '0;
                        div_start   = 1'b1;
                        state_next  = ST_DIV;
                    end
                    else if (!(&count_reg))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    // Skip the BCD pass when the display shows dashes.
                    range_next = (quotient <= MAX_CENTIHZ);
                    if (quotient <= MAX_CENTIHZ)
                    begin
                        bcd_start  = 1'b1;
                        state_next = ST_BCD;
                    end
                    else
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_BCD:
            begin
                if (bcd_status.done)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load           = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            range_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            range_reg     <= range_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
    end

    // Clamp a wide period to 32 bits for the result field.
    assign period_ext = PER_EXT_W'(period_reg);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (period_ext > PER_EXT_W'(32'hffff_ffff))
                period_out_reg <= 32'hffff_ffff;
            else
                period_out_reg <= period_ext[31:0];
            range_out_reg <= range_reg;
            if (range_reg)
            begin
                centi_reg      <= quotient[CENTI_W-1:0];
                seg_tens_reg   <= seg_drive(bcd[15:12], 1'b0);
                seg_units_reg  <= seg_drive(bcd[11:8], 1'b1);
                seg_tenths_reg <= seg_drive(bcd[7:4], 1'b0);
                seg_hund_reg   <= seg_drive(bcd[3:0], 1'b0);
            end
            else
            begin
                centi_reg      <= '0;
                seg_tens_reg   <= seg_drive(DIGIT_DASH, 1'b0);
                seg_units_reg  <= seg_drive(DIGIT_DASH, 1'b0);
                seg_tenths_reg <= seg_drive(DIGIT_DASH, 1'b0);
                seg_hund_reg   <= seg_drive(DIGIT_DASH, 1'b0);
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign period_ticks   = period_out_reg;
    assign centihertz     = centi_reg;
    assign in_range       = range_out_reg;
    assign seg_tens       = seg_tens_reg;
    assign seg_units      = seg_units_reg;
    assign seg_tenths     = seg_tenths_reg;
    assign seg_hundredths = seg_hund_reg;

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider done outside of divide state");

    // The BCD converter finishes only while the sequencer waits for it.
    a_bcd_done_in_bcd: assert property (@(posedge clk) disable iff (!rst_n)
        bcd_status.done |-> state_reg == ST_BCD)
        else $error("bcd done outside of convert state");

    // An edge transfer starts the divider in the next cycle.
    a_edge_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && edge_req |=> state_reg == ST_DIV && div_status.busy)
        else $error("edge transfer did not start the divider");

    // A shown in-range reading never exceeds 99.99 Hz.
    a_range_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> centihertz <= CENTI_W'(9999))
        else $error("in-range reading above limit");

    // An out-of-range reading shows dashes and a zero reading.
    a_dash_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> centihertz == '0 && seg_tens == 8'hbf
            && seg_units == 8'hbf && seg_tenths == 8'hbf && seg_hundredths == 8'hbf)
        else $error("out-of-range reading not shown as dashes");

endmodule
